FILE: rtl/rbfe_pkg.sv
package rbfe_pkg;

  localparam int unsigned TimeW  = 16;
  localparam int unsigned LevelW = 8;
  localparam int unsigned ElapW  = 17;
  localparam int unsigned StepW  = 8;
  localparam int unsigned NumW   = TimeW + LevelW;
  localparam int unsigned CntW   = 5;
  localparam int unsigned AddrW  = 5;

  localparam logic [ElapW-1:0] ElapMax = '1;

  localparam logic [TimeW-1:0]  MinBrightRst = 16'd60;
  localparam logic [TimeW-1:0]  MaxBrightRst = 16'd120;
  localparam logic [TimeW-1:0]  MinDarkRst   = 16'd10;
  localparam logic [TimeW-1:0]  MaxDarkRst   = 16'd40;
  localparam logic [LevelW-1:0] CeilingRst   = 8'd64;
  localparam logic [StepW-1:0]  StepRst      = 8'd1;

  // divider pass lengths
  localparam logic [CntW-1:0] ModSteps = 5'd16;
  localparam logic [CntW-1:0] EnvSteps = 5'd8;

  localparam logic [2:0] RegMinBright = 3'd0;
  localparam logic [2:0] RegMaxBright = 3'd1;
  localparam logic [2:0] RegMinDark   = 3'd2;
  localparam logic [2:0] RegMaxDark   = 3'd3;
  localparam logic [2:0] RegCeiling   = 3'd4;
  localparam logic [2:0] RegStep      = 3'd5;

  localparam logic [1:0] ModeTick    = 2'd0;
  localparam logic [1:0] ModeSetLim  = 2'd1;
  localparam logic [1:0] ModeRestore = 2'd2;

  typedef struct packed {
    logic [TimeW-1:0]  min_bright;
    logic [TimeW-1:0]  max_bright;
    logic [TimeW-1:0]  min_dark;
    logic [TimeW-1:0]  max_dark;
    logic [LevelW-1:0] ceiling;
    logic [StepW-1:0]  step;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [CntW-1:0]   steps;
    logic [TimeW-1:0]  rem_init;
    logic [NumW-1:0]   dividend;
    logic [TimeW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [LevelW-1:0] quot;
    logic [TimeW-1:0]  rem;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW,
    ST_DRAW_WAIT,
    ST_ADVANCE,
    ST_ENV_MUL,
    ST_ENV_DIV,
    ST_ENV_WAIT,
    ST_EMIT
  } st_e;

endpackage

FILE: rtl/rbfe_cfg.sv
module rbfe_cfg import rbfe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegMinBright: cfg_d.min_bright = pwdata[TimeW-1:0];
        RegMaxBright: cfg_d.max_bright = pwdata[TimeW-1:0];
        RegMinDark:   cfg_d.min_dark   = pwdata[TimeW-1:0];
        RegMaxDark:   cfg_d.max_dark   = pwdata[TimeW-1:0];
        RegCeiling:   cfg_d.ceiling    = pwdata[LevelW-1:0];
        RegStep:      cfg_d.step       = pwdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegMinBright: prdata = 32'(cfg_q.min_bright);
      RegMaxBright: prdata = 32'(cfg_q.max_bright);
      RegMinDark:   prdata = 32'(cfg_q.min_dark);
      RegMaxDark:   prdata = 32'(cfg_q.max_dark);
      RegCeiling:   prdata = 32'(cfg_q.ceiling);
      RegStep:      prdata = 32'(cfg_q.step);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_bright <= MinBrightRst;
      cfg_q.max_bright <= MaxBrightRst;
      cfg_q.min_dark   <= MinDarkRst;
      cfg_q.max_dark   <= MaxDarkRst;
      cfg_q.ceiling    <= CeilingRst;
      cfg_q.step       <= StepRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/rbfe_div.sv
module rbfe_div import rbfe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [TimeW-1:0]  r_q, r_d;
  logic [TimeW-1:0]  d_q, d_d;
  logic [NumW-1:0]   n_q, n_d;
  logic [LevelW-1:0] q_q, q_d;
  logic [TimeW:0]    trial;
  logic              fits;

  // one restoring step per cycle
  assign trial = {r_q, n_q[NumW-1]};
  assign fits  = trial >= {1'b0, d_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    d_d    = d_q;
    n_d    = n_q;
    q_d    = q_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      r_d    = req_i.rem_init;
      d_d    = req_i.divisor;
      n_d    = req_i.dividend;
      q_d    = '0;
    end else if (busy_q) begin
      r_d   = fits ? TimeW'(trial - {1'b0, d_q}) : trial[TimeW-1:0];
      n_d   = {n_q[NumW-2:0], 1'b0};
      q_d   = {q_q[LevelW-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    d_q <= d_d;
    n_q <= n_d;
    q_q <= q_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = q_q;
  assign rsp_o.rem  = r_q;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (r_q < d_q))
    else $error("divider remainder not below divisor");

endmodule

FILE: rtl/random_blink_fade_envelope.sv
// A tick's path from acceptance to result is longest on the first tick and on a phase flip, which each add
//   a 16-step modulo pass; the level adds an 8-step divide.
// Throughput: one transaction at a time; limit transactions give no result.
// All division and modulo run through one shared restoring divider.
// Reset: asynchronous, active low; registers at their reset values, dark phase, not started.
module random_blink_fade_envelope import rbfe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic [LevelW-1:0] limit_value_i,
  input  logic [TimeW-1:0]  random_bits_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [LevelW-1:0] level_o,
  output logic              level_changed_o,
  output logic              bright_phase_o
);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  st_e st_q, st_d;

  logic              phase_q, phase_d;
  logic              started_q, started_d;
  logic [ElapW-1:0]  elap_q, elap_d;
  logic [TimeW-1:0]  hold_q, hold_d;
  logic [LevelW-1:0] limit_q, limit_d;
  logic [LevelW-1:0] last_q, last_d;
  logic [TimeW-1:0]  rnd_q, rnd_d;
  logic [NumW-1:0]   mul_q, mul_d;
  logic [LevelW-1:0] lvl_q, lvl_d;
  logic              ov_q, ov_d;
  logic [LevelW-1:0] olvl_q, olvl_d;
  logic              ochg_q, ochg_d;
  logic              ophase_q, ophase_d;

  logic              in_acc;
  logic              out_free;
  logic [TimeW-1:0]  lo, hi;
  logic              range_ok;
  logic [ElapW:0]    sum;
  logic [ElapW-1:0]  sat;
  logic              flip;
  logic [ElapW+3:0]  e10;
  logic              e_below;
  logic              ramp;

  rbfe_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rbfe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o = (st_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !ov_q || !out_stall_i;

  assign lo       = phase_q ? cfg.min_bright : cfg.min_dark;
  assign hi       = phase_q ? cfg.max_bright : cfg.max_dark;
  assign range_ok = hi > lo;

  assign sum     = {1'b0, elap_q} + (ElapW+1)'(cfg.step);
  assign sat     = sum[ElapW] ? ElapMax : sum[ElapW-1:0];
  assign flip    = sat >= ElapW'(hold_q);
  assign e10     = (ElapW+4)'({elap_q, 3'b000}) + (ElapW+4)'({elap_q, 1'b0});
  assign e_below = elap_q < ElapW'(hold_q);
  assign ramp    = e10 < (ElapW+4)'(hold_q);

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_acc && mode_i == ModeTick) st_d = started_q ? ST_ADVANCE : ST_DRAW;
      end
      ST_DRAW: begin
        if (range_ok)       st_d = ST_DRAW_WAIT;
        else if (started_q) st_d = ST_ENV_MUL;
        else                st_d = ST_ADVANCE;
      end
      ST_DRAW_WAIT: begin
        if (div_rsp.done) st_d = started_q ? ST_ENV_MUL : ST_ADVANCE;
      end
      ST_ADVANCE: st_d = flip ? ST_DRAW : ST_ENV_MUL;
      ST_ENV_MUL: begin
        if (hold_q == '0)  st_d = ST_EMIT;
        else if (phase_q)  st_d = ramp ? ST_ENV_DIV : ST_EMIT;
        else               st_d = e_below ? ST_ENV_DIV : ST_EMIT;
      end
      ST_ENV_DIV:  st_d = ST_ENV_WAIT;
      ST_ENV_WAIT: begin
        if (div_rsp.done) st_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    started_d = started_q;
    elap_d    = elap_q;
    hold_d    = hold_q;
    limit_d   = limit_q;
    last_d    = last_q;
    rnd_d     = rnd_q;
    mul_d     = mul_q;
    lvl_d     = lvl_q;
    ov_d      = ov_q && out_stall_i;
    olvl_d    = olvl_q;
    ochg_d    = ochg_q;
    ophase_d  = ophase_q;
    div_req   = '0;
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          rnd_d = random_bits_i;
          case (mode_i)
            ModeTick: begin
              if (!started_q) phase_d = 1'b0;
            end
            ModeSetLim:  limit_d = (limit_value_i > cfg.ceiling) ? cfg.ceiling : limit_value_i;
            ModeRestore: limit_d = cfg.ceiling;
            default: ;
          endcase
        end
      end
      ST_DRAW: begin
        if (range_ok) begin
          div_req.start    = 1'b1;
          div_req.steps    = ModSteps;
          div_req.rem_init = '0;
          div_req.dividend = {rnd_q, LevelW'(0)};
          div_req.divisor  = hi - lo;
        end else begin
          hold_d    = lo;
          started_d = 1'b1;
        end
      end
      ST_DRAW_WAIT: begin
        if (div_rsp.done) begin
          hold_d    = lo + div_rsp.rem;
          started_d = 1'b1;
        end
      end
      ST_ADVANCE: begin
        if (flip) begin
          elap_d  = sat - ElapW'(hold_q);
          phase_d = !phase_q;
        end else begin
          elap_d = sat;
        end
      end
      ST_ENV_MUL: begin
        if (hold_q == '0) begin
          lvl_d = phase_q ? limit_q : '0;
        end else if (phase_q) begin
          lvl_d = limit_q;
          mul_d = NumW'(limit_q) * NumW'(e10[TimeW-1:0]);
        end else begin
          lvl_d = '0;
          mul_d = NumW'(limit_q) * NumW'(hold_q - elap_q[TimeW-1:0]);
        end
      end
      ST_ENV_DIV: begin
        div_req.start    = 1'b1;
        div_req.steps    = EnvSteps;
        div_req.rem_init = mul_q[NumW-1:LevelW];
        div_req.dividend = {mul_q[LevelW-1:0], TimeW'(0)};
        div_req.divisor  = hold_q;
      end
      ST_ENV_WAIT: begin
        if (div_rsp.done) lvl_d = div_rsp.quot;
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_d     = 1'b1;
          olvl_d   = lvl_q;
          ochg_d   = lvl_q != last_q;
          ophase_d = phase_q;
          last_d   = lvl_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      phase_q   <= 1'b0;
      started_q <= 1'b0;
      elap_q    <= '0;
      hold_q    <= '0;
      limit_q   <= CeilingRst;
      last_q    <= CeilingRst;
      ov_q      <= 1'b0;
    end else begin
      st_q      <= st_d;
      phase_q   <= phase_d;
      started_q <= started_d;
      elap_q    <= elap_d;
      hold_q    <= hold_d;
      limit_q   <= limit_d;
      last_q    <= last_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q    <= rnd_d;
    mul_q    <= mul_d;
    lvl_q    <= lvl_d;
    olvl_q   <= olvl_d;
    ochg_q   <= ochg_d;
    ophase_q <= ophase_d;
  end

  assign out_valid_o     = ov_q;
  assign level_o         = olvl_q;
  assign level_changed_o = ochg_q;
  assign bright_phase_o  = ophase_q;

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_env_nonzero_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_ENV_DIV || st_q == ST_ENV_WAIT) |-> (hold_q != '0))
    else $error("level divide with zero hold time");

  a_level_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EMIT) |-> (lvl_q <= limit_q))
    else $error("level above limit");

  a_start_in_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(started_q) |-> !phase_q)
    else $error("first hold time not drawn in dark phase");

endmodule
